>>> rtl/core/mbe_pkg.sv
// shared types and constants for the mandelbrot escape-time block
package mbe_pkg;

   localparam int CELL_COUNT      = 4;
   localparam int COUNT_WIDTH     = 16;
   localparam int RADIUS_WIDTH    = 31;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_MAX_ITERATIONS   = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_ESCAPE_RADIUS_SQ = 4'd1;

   localparam logic [COUNT_WIDTH-1:0]  MAX_ITERATIONS_RESET   = 16'd256;
   localparam logic [RADIUS_WIDTH-1:0] ESCAPE_RADIUS_SQ_RESET = 31'h4000_0000;

   // control that travels with the point around the ring
   typedef struct packed {
      logic valid;
      logic done;
      logic escaped;
   } token_ctl_type;

   // configuration seen by every cell
   typedef struct packed {
      logic [COUNT_WIDTH-1:0]  max_iterations;
      logic [RADIUS_WIDTH-1:0] escape_radius_sq;
   } cfg_type;

endpackage

>>> rtl/core/mbe_cell.sv
// one iteration cell: z*z + c with magnitude test, two register stages
module mbe_cell import mbe_pkg::*; #(
   parameter int COORD_WIDTH   = 32,
   parameter int FRACTION_BITS = 28
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  logic signed [COORD_WIDTH-1:0] c_real,
   input  logic signed [COORD_WIDTH-1:0] c_imag,
   input  token_ctl_type                 src_ctl,
   input  logic signed [COORD_WIDTH-1:0] src_x,
   input  logic signed [COORD_WIDTH-1:0] src_y,
   input  logic [COUNT_WIDTH-1:0]        src_count,
   output token_ctl_type                 dst_ctl,
   output logic signed [COORD_WIDTH-1:0] dst_x,
   output logic signed [COORD_WIDTH-1:0] dst_y,
   output logic [COUNT_WIDTH-1:0]        dst_count
);

   localparam int PROD_W = 2 * COORD_WIDTH;
   localparam int MAG_W  = PROD_W - FRACTION_BITS;
   localparam int CMP_W  = (MAG_W > RADIUS_WIDTH) ? MAG_W : RADIUS_WIDTH;
   localparam int SUM_W  = PROD_W - FRACTION_BITS + 3;

   localparam logic signed [SUM_W-1:0] SAT_HI =
      {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO =
      {{(SUM_W-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

   // product stage
   token_ctl_type             ctl_p_ff, ctl_p_in;
   logic signed [PROD_W-1:0]  sx_ff, sx_in;
   logic signed [PROD_W-1:0]  sy_ff, sy_in;
   logic signed [PROD_W-1:0]  sxy_ff, sxy_in;
   logic [COUNT_WIDTH-1:0]    count_p_ff;

   // update stage
   token_ctl_type                 ctl_ff, ctl_in;
   logic signed [COORD_WIDTH-1:0] x_ff, x_in;
   logic signed [COORD_WIDTH-1:0] y_ff, y_in;
   logic [COUNT_WIDTH-1:0]        count_ff, count_in;

   logic [PROD_W-1:0]         mag_sum;
   logic [MAG_W-1:0]          mag;
   logic                      outside;
   logic signed [SUM_W-1:0]   xx, yy, xy, re_sum, im_sum;

   always_comb begin
      sx_in  = src_x * src_x;
      sy_in  = src_y * src_y;
      sxy_in = src_x * src_y;
      ctl_p_in = src_ctl;
      // limit reached: no more tests
      if (src_ctl.valid && !(src_count < cfg.max_iterations)) begin
         ctl_p_in.done = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_p_ff <= '0;
      end else begin
         ctl_p_ff <= ctl_p_in;
      end
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      sxy_ff     <= sxy_in;
      count_p_ff <= src_count;
   end

   always_comb begin
      mag_sum = unsigned'(sx_ff) + unsigned'(sy_ff);
      mag     = mag_sum[PROD_W-1:FRACTION_BITS];
      outside = CMP_W'(mag) > CMP_W'(cfg.escape_radius_sq);

      xx = SUM_W'(sx_ff >>> FRACTION_BITS);
      yy = SUM_W'(sy_ff >>> FRACTION_BITS);
      xy = SUM_W'(sxy_ff >>> (FRACTION_BITS - 1));
      re_sum = xx - yy + SUM_W'(c_real);
      im_sum = xy + SUM_W'(c_imag);

      ctl_in   = ctl_p_ff;
      x_in     = re_sum[COORD_WIDTH-1:0];
      y_in     = im_sum[COORD_WIDTH-1:0];
      count_in = count_p_ff;
      if (re_sum > SAT_HI) begin
         x_in = SAT_HI[COORD_WIDTH-1:0];
      end else if (re_sum < SAT_LO) begin
         x_in = SAT_LO[COORD_WIDTH-1:0];
      end
      if (im_sum > SAT_HI) begin
         y_in = SAT_HI[COORD_WIDTH-1:0];
      end else if (im_sum < SAT_LO) begin
         y_in = SAT_LO[COORD_WIDTH-1:0];
      end
      if (ctl_p_ff.valid && !ctl_p_ff.done) begin
         if (outside) begin
            ctl_in.done    = 1'b1;
            ctl_in.escaped = 1'b1;
         end else begin
            count_in = count_p_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
      end
      x_ff     <= x_in;
      y_ff     <= y_in;
      count_ff <= count_in;
   end

   assign dst_ctl   = ctl_ff;
   assign dst_x     = x_ff;
   assign dst_y     = y_ff;
   assign dst_count = count_ff;

endmodule

>>> rtl/core/mandelbrot_escape_iteration.sv
// top level: mandelbrot escape-time iteration over a ring of iteration cells
//
// one point at a time. a point beat is taken when start is high and busy is low;
// busy stays high until its result is shown. the point circulates around a
// ring of CELL_COUNT (4) identical cells; each cell does one z = z*z + c update
// and the escape test through two registers (a product register, then the add,
// saturate and compare register). the finished point is picked up where the ring
// wraps and registered into the result strobe rsp_valid. the result is on the
// rsp_ ports for one cycle only and the receiver cannot stall it; busy drops at
// the edge that puts the result on the ports, so the next point can be started
// while the result is on the ports. config writes are always ready and take
// effect at once; write them only while busy is low. writes to unknown register
// indexes are dropped.
module mandelbrot_escape_iteration import mbe_pkg::*; #(
   parameter int COORD_WIDTH   = 32,
   parameter int FRACTION_BITS = 28
) (
   input  logic                          clock,
   input  logic                          reset,
   // point channel
   input  logic                          start,
   output logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_c_real,
   input  logic signed [COORD_WIDTH-1:0] req_c_imag,
   // result channel
   output logic                          rsp_valid,
   output logic [COUNT_WIDTH-1:0]        rsp_iteration_count,
   output logic                          rsp_escaped,
   // register write channel
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_wdata
);

   // config registers
   cfg_type cfg_ff, cfg_in;

   // point held for the whole run, c is added in every cell
   logic signed [COORD_WIDTH-1:0] c_real_ff, c_imag_ff;
   logic                          busy_ff, busy_in;
   logic                          accept;

   // ring links: cell i output feeds cell i+1, the last wraps to the first
   token_ctl_type                 ring_ctl   [CELL_COUNT];
   logic signed [COORD_WIDTH-1:0] ring_x     [CELL_COUNT];
   logic signed [COORD_WIDTH-1:0] ring_y     [CELL_COUNT];
   logic [COUNT_WIDTH-1:0]        ring_count [CELL_COUNT];
   logic [CELL_COUNT-1:0]         ring_valid;

   // what enters the first cell
   token_ctl_type                 feed_ctl;
   logic signed [COORD_WIDTH-1:0] feed_x, feed_y;
   logic [COUNT_WIDTH-1:0]        feed_count;

   // result register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;
   logic                   rsp_escaped_ff;
   token_ctl_type          wrap_ctl;
   logic                   finish;

   assign accept    = start && !busy_ff;
   assign csr_ready = 1'b1;
   assign wrap_ctl  = ring_ctl[CELL_COUNT-1];
   assign finish    = wrap_ctl.valid && wrap_ctl.done;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MAX_ITERATIONS:   cfg_in.max_iterations   = csr_wdata[COUNT_WIDTH-1:0];
            REG_ESCAPE_RADIUS_SQ: cfg_in.escape_radius_sq = csr_wdata[RADIUS_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // ring entry: a new point, or the circulating point while it is still running
   always_comb begin
      feed_ctl   = '0;
      feed_x     = ring_x[CELL_COUNT-1];
      feed_y     = ring_y[CELL_COUNT-1];
      feed_count = ring_count[CELL_COUNT-1];
      if (accept) begin
         feed_ctl.valid = 1'b1;
         feed_x         = req_c_real;
         feed_y         = req_c_imag;
         feed_count     = '0;
      end else if (wrap_ctl.valid && !wrap_ctl.done) begin
         feed_ctl = wrap_ctl;
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (finish) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = finish;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_iterations   <= MAX_ITERATIONS_RESET;
         cfg_ff.escape_radius_sq <= ESCAPE_RADIUS_SQ_RESET;
         busy_ff                 <= 1'b0;
         rsp_valid_ff            <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         c_real_ff <= req_c_real;
         c_imag_ff <= req_c_imag;
      end
      if (finish) begin
         rsp_count_ff   <= ring_count[CELL_COUNT-1];
         rsp_escaped_ff <= wrap_ctl.escaped;
      end
   end

   // the ring of cells
   for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
      if (i == 0) begin : g_head
         mbe_cell #(
            .COORD_WIDTH   (COORD_WIDTH),
            .FRACTION_BITS (FRACTION_BITS)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .cfg       (cfg_ff),
            .c_real    (c_real_ff),
            .c_imag    (c_imag_ff),
            .src_ctl   (feed_ctl),
            .src_x     (feed_x),
            .src_y     (feed_y),
            .src_count (feed_count),
            .dst_ctl   (ring_ctl[i]),
            .dst_x     (ring_x[i]),
            .dst_y     (ring_y[i]),
            .dst_count (ring_count[i])
         );
      end else begin : g_body
         mbe_cell #(
            .COORD_WIDTH   (COORD_WIDTH),
            .FRACTION_BITS (FRACTION_BITS)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .cfg       (cfg_ff),
            .c_real    (c_real_ff),
            .c_imag    (c_imag_ff),
            .src_ctl   (ring_ctl[i-1]),
            .src_x     (ring_x[i-1]),
            .src_y     (ring_y[i-1]),
            .src_count (ring_count[i-1]),
            .dst_ctl   (ring_ctl[i]),
            .dst_x     (ring_x[i]),
            .dst_y     (ring_y[i]),
            .dst_count (ring_count[i])
         );
      end
      assign ring_valid[i] = ring_ctl[i].valid;
   end

   assign busy                = busy_ff;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_iteration_count = rsp_count_ff;
   assign rsp_escaped         = rsp_escaped_ff;

   // a result only follows a running point
   a_result_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy_ff))
      else $error("result strobe without a running point");

   // one result beat per point
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe repeated");

   // never more than one point on the ring
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(ring_valid) <= 1)
      else $error("more than one point in the ring");

   // idle means an empty ring
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> ring_valid == '0)
      else $error("ring holds a point while idle");

   // the result never reports more updates than the limit
   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_iteration_count <= cfg_ff.max_iterations)
      else $error("iteration count beyond the limit");

endmodule

>>> dv/mbe_checker.sv
// checker for the escape-time block: predicts each point's count and escape flag
module mbe_checker import mbe_pkg::*; #(
   parameter int COORD_WIDTH   = 32,
   parameter int FRACTION_BITS = 28
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  logic signed [COORD_WIDTH-1:0] req_c_real,
   input  logic signed [COORD_WIDTH-1:0] req_c_imag,
   input  logic                          rsp_valid,
   input  logic [COUNT_WIDTH-1:0]        rsp_iteration_count,
   input  logic                          rsp_escaped,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]     csr_wdata,
   output int                            mismatch_count,
   output int                            points_in_flight
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint COORD_MAX = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
   localparam longint COORD_MIN = -COORD_MAX - 1;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] iteration_count;
      logic                   escaped;
   } escape_result_type;

   logic [COUNT_WIDTH-1:0]  iter_limit;
   logic [RADIUS_WIDTH-1:0] radius_sq;
   escape_result_type       expected_results[$];

   function automatic longint clamp_coord(longint v);
      if (v > COORD_MAX) return COORD_MAX;
      if (v < COORD_MIN) return COORD_MIN;
      return v;
   endfunction

   // exact products, floor shifts, saturating z update
   function automatic escape_result_type escape_time_of(longint cr, longint ci);
      escape_result_type r;
      longint            x, y, sx, sy, nx;
      logic [64:0]       mag;
      int unsigned       n;
      x = cr;
      y = ci;
      n = 0;
      r.escaped = 1'b0;
      while (n < iter_limit && !r.escaped) begin
         sx  = x * x;
         sy  = y * y;
         mag = ({1'b0, sx} + {1'b0, sy}) >> FRACTION_BITS;
         if (mag > 65'(radius_sq)) begin
            r.escaped = 1'b1;
         end else begin
            nx = clamp_coord((sx >>> FRACTION_BITS) - (sy >>> FRACTION_BITS) + cr);
            y  = clamp_coord(((x * y) >>> (FRACTION_BITS - 1)) + ci);
            x  = nx;
            n++;
         end
      end
      r.iteration_count = n[COUNT_WIDTH-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      escape_result_type want;
      if (reset) begin
         iter_limit = MAX_ITERATIONS_RESET;
         radius_sq  = ESCAPE_RADIUS_SQ_RESET;
         expected_results.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_results.size() == 0) begin
               $error("result beat with no point outstanding");
               mismatch_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_iteration_count !== want.iteration_count) begin
                  $error("iteration_count: expected %0d, got %0d",
                         want.iteration_count, rsp_iteration_count);
                  mismatch_count++;
               end
               if (rsp_escaped !== want.escaped) begin
                  $error("escaped: expected %0b, got %0b", want.escaped, rsp_escaped);
                  mismatch_count++;
               end
            end
         end
         if (start && !busy)
            expected_results.push_back(escape_time_of(req_c_real, req_c_imag));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MAX_ITERATIONS:   iter_limit = csr_wdata[COUNT_WIDTH-1:0];
               REG_ESCAPE_RADIUS_SQ: radius_sq  = csr_wdata[RADIUS_WIDTH-1:0];
               default: ;
            endcase
         end
      end
      points_in_flight = expected_results.size();
   end

endmodule

>>> dv/tb_top.sv
// testbench top: stimulus and verdict for the mandelbrot escape-time block
module tb_top import mbe_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   // silence longer than the slowest point (65535 updates) times three
   localparam int WATCHDOG_LIMIT   = 400_000;
   localparam int SETTLE_CYCLES    = 12;
   localparam int RANDOM_PHASES    = 12;
   localparam int POINTS_PER_PHASE = 62;

   // register indexes the block does not decode
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNMAPPED_LOW  = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNMAPPED_HIGH = 4'd15;

   // q4.28 values used by the directed points
   localparam logic [31:0] Q_ZERO       = 32'h0000_0000;
   localparam logic [31:0] Q_ONE        = 32'h1000_0000;
   localparam logic [31:0] Q_MINUS_ONE  = 32'hF000_0000;
   localparam logic [31:0] Q_TWO        = 32'h2000_0000;
   localparam logic [31:0] Q_MINUS_TWO  = 32'hE000_0000;
   localparam logic [31:0] Q_QUARTER    = 32'h0400_0000;
   localparam logic [31:0] Q_ONE_HALF3  = 32'h1800_0000;
   localparam logic [31:0] Q_MAX        = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MIN        = 32'h8000_0000;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   logic signed [31:0]            req_c_real;
   logic signed [31:0]            req_c_imag;
   logic                          rsp_valid;
   logic [COUNT_WIDTH-1:0]        rsp_iteration_count;
   logic                          rsp_escaped;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index;
   logic [CSR_DATA_WIDTH-1:0]     csr_wdata;

   int mismatch_count;
   int points_in_flight;
   int quiet_cycles;
   int burst_left;

   mandelbrot_escape_iteration dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_c_real          (req_c_real),
      .req_c_imag          (req_c_imag),
      .rsp_valid           (rsp_valid),
      .rsp_iteration_count (rsp_iteration_count),
      .rsp_escaped         (rsp_escaped),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   mbe_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_c_real          (req_c_real),
      .req_c_imag          (req_c_imag),
      .rsp_valid           (rsp_valid),
      .rsp_iteration_count (rsp_iteration_count),
      .rsp_escaped         (rsp_escaped),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .mismatch_count      (mismatch_count),
      .points_in_flight    (points_in_flight)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // any beat on any channel restarts the count; a hang ends the run
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // one point beat; start stays high through a burst, then drops for a random gap
   task automatic send_point(input logic [31:0] cr, input logic [31:0] ci);
      int gap;
      start      <= 1'b1;
      req_c_real <= cr;
      req_c_imag <= ci;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 7);
         // mostly short gaps, some long enough to land anywhere in a 256-update point
         case ($urandom_range(0, 9))
            0, 1, 2, 3: gap = 0;
            4, 5, 6, 7: gap = $urandom_range(1, 12);
            8:          gap = $urandom_range(13, 80);
            default:    gap = $urandom_range(81, 600);
         endcase
         if (gap > 0) begin
            start      <= 1'b0;
            req_c_real <= $urandom;
            req_c_imag <= $urandom;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_index <= CSR_INDEX_WIDTH'($urandom);
      csr_wdata <= $urandom;
      @(negedge clock);
   endtask

   // stop sending and let every outstanding point come back
   task automatic settle();
      if (start) start <= 1'b0;
      while (points_in_flight != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // unused upper data bits are random so the register masking gets exercised
   task automatic configure(input logic [COUNT_WIDTH-1:0] limit,
                            input logic [RADIUS_WIDTH-1:0] radius);
      settle();
      write_reg(REG_MAX_ITERATIONS, {16'($urandom), limit});
      write_reg(REG_ESCAPE_RADIUS_SQ, {1'($urandom), radius});
   endtask

   initial begin
      logic [31:0]             cr, ci;
      logic [COUNT_WIDTH-1:0]  limit;
      logic [RADIUS_WIDTH-1:0] radius;
      reset      = 1'b1;
      start      = 1'b0;
      req_c_real = '0;
      req_c_imag = '0;
      csr_valid  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      burst_left = 0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: limit 256, radius squared 4.0
      send_point(Q_ZERO, Q_ZERO);               // never leaves, runs to the limit
      send_point(Q_TWO, Q_ZERO);                // magnitude exactly on the radius
      send_point(Q_MINUS_TWO, Q_ZERO);          // fixed point at 2, stays on the radius
      send_point(Q_TWO + 32'd1, Q_ZERO);        // just outside, escapes before any update
      send_point(Q_MINUS_ONE, Q_ZERO);          // period-two orbit
      send_point(Q_ZERO, Q_ONE);                // orbit through -1+i
      send_point(Q_QUARTER, Q_ZERO);            // slow convergence on the cusp
      send_point(32'hF400_0000, 32'h0199_999A); // -0.75 + 0.1i near the neck
      send_point(Q_MAX, Q_MAX);                 // coordinate extremes
      send_point(Q_MIN, Q_MIN);
      send_point(Q_MIN, Q_MAX);
      send_point(Q_ZERO, Q_MIN);

      // writes to undecoded indexes must leave both registers alone
      settle();
      write_reg(REG_UNMAPPED_LOW, $urandom);
      write_reg(REG_UNMAPPED_HIGH, $urandom);
      send_point(Q_ONE_HALF3, Q_ONE_HALF3);

      // zero iteration limit: no test and no update
      configure('0, '1);
      send_point(Q_MAX, Q_ZERO);
      send_point(Q_ZERO, Q_ZERO);

      // single update, zero radius: only a magnitude that floors to zero survives
      configure(16'd1, '0);
      send_point(Q_ZERO, Q_ZERO);
      send_point(32'h0000_3FFF, Q_ZERO);
      send_point(32'h0000_4000, Q_ZERO);

      // largest limit: one full-length point, one quick escape
      configure('1, ESCAPE_RADIUS_SQ_RESET);
      send_point(Q_ZERO, Q_ZERO);
      send_point(Q_ONE_HALF3, Q_ONE_HALF3);

      // widest radius so z can grow far enough to clamp each way
      configure(16'd24, '1);
      send_point(32'h2CCC_CCCD, Q_ZERO);         // real part clamps high
      send_point(32'h1E66_6666, 32'h1E66_6666);  // imaginary part clamps high
      send_point(32'h1E66_6666, 32'hE199_999A);  // imaginary part clamps low
      send_point(32'hD800_0000, Q_ZERO);

      // random phases, mostly points inside the interesting window
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 3)
            limit = MAX_ITERATIONS_RESET;
         else if (p == 7)
            limit = 16'd1;
         else
            limit = COUNT_WIDTH'($urandom_range(2, 64));
         case ($urandom_range(0, 4))
            0:       radius = ESCAPE_RADIUS_SQ_RESET;
            1:       radius = '1;
            2:       radius = RADIUS_WIDTH'($urandom);
            3:       radius = RADIUS_WIDTH'($urandom_range(0, 32'h0100_0000));
            default: radius = 31'h1000_0000;
         endcase
         configure(limit, radius);
         for (int i = 0; i < POINTS_PER_PHASE; i++) begin
            case ($urandom_range(0, 19))
               0, 1: begin
                  // anywhere in the coordinate range
                  cr = $urandom;
                  ci = $urandom;
               end
               2: begin
                  // around the origin, at most two units of the squared magnitude
                  cr = $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
                  ci = $urandom_range(0, 32'h0000_8000) - 32'h0000_4000;
               end
               default: begin
                  // [-2.5, 1.0] x [-1.5, 1.5]
                  cr = $urandom_range(0, 32'h3800_0000) - 32'h2800_0000;
                  ci = $urandom_range(0, 32'h3000_0000) - 32'h1800_0000;
               end
            endcase
            send_point(cr, ci);
         end
      end

      settle();
      if (mismatch_count == 0 && points_in_flight == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

>>> files.f
rtl/core/mbe_pkg.sv
rtl/core/mbe_cell.sv
rtl/core/mandelbrot_escape_iteration.sv
dv/mbe_checker.sv
dv/tb_top.sv
